// ===== design/roberts_cross_edge_magnitude_unit_defines.svh =====
// assertion macros for the roberts cross edge magnitude unit
`ifndef ROBERTS_CROSS_EDGE_MAGNITUDE_UNIT_DEFINES_SVH
`define ROBERTS_CROSS_EDGE_MAGNITUDE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define RCEM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define RCEM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RCEM_ASSERT_IMP(lbl, ante, cons, msg)

`define RCEM_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/rcem_pkg.sv =====
// shared types and constants of the roberts cross edge magnitude unit
`default_nettype none

package rcem_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int PIX_W  = 8;
    localparam int MAG_W  = 9;
    localparam int CFG_W  = 11;
    localparam int SQ_W   = 2 * PIX_W;
    localparam int RAD_W  = SQ_W + 1;
    localparam int ROOT_W = RAD_W + 1;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 11'd480;
    localparam logic [RAD_W-1:0] ROOT_FIRST_BIT   = 17'h10000;
    localparam logic [MAG_W-1:0] MAG_MAX          = 9'd360;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic accept;
        logic window;
        logic sum;
        logic step;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic root_last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== design/rcem_pixel_if.sv =====
// pixel channel interface
`default_nettype none

interface rcem_pixel_if
    import rcem_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

// ===== design/rcem_result_if.sv =====
// result channel interface
`default_nettype none

interface rcem_result_if
    import rcem_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [MAG_W-1:0] magnitude;
    logic             end_of_line;
    logic             end_of_frame;

    modport source (output valid, output magnitude, output end_of_line,
                    output end_of_frame, input ready);
    modport sink   (input valid, input magnitude, input end_of_line,
                    input end_of_frame, output ready);
endinterface

`default_nettype wire

// ===== design/roberts_cross_edge_magnitude_unit.sv =====
// top level of the roberts cross edge magnitude unit
`default_nettype none

// Streams 8-bit grayscale pixels in raster order and returns the Roberts cross
// magnitude floor(sqrt(gx^2 + gy^2)) of each 2x2 window, one result for every
// pixel past the first row and first column, so a W x H frame gives
// (W-1) x (H-1) words, flagged at the end of each line and of the frame.
// One pixel is in work at a time: a pixel that yields a result goes through
// accept with line store read, squares, sum, nine one-bit-per-cycle iterations
// of the square root unit and output load, which waits while the receiver
// still holds the previous word in the output register; a pixel on the first
// row or first column returns to idle after the line store read. The square
// root unit sets the rate. The finished word waits in an output register, so
// the next pixel is taken while it is pending. The previous line lives in a
// single-port read-before-write memory of MAX_WIDTH entries with no clearing
// pass. Width and height are saturated to 2..MAX_WIDTH and 2..MAX_HEIGHT; the
// user must write them only while the unit is idle; the unit does not check it.
module roberts_cross_edge_magnitude_unit
    import rcem_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire              i_cfg_idx,
    input  wire [CFG_W-1:0]  i_cfg_data,
    rcem_pixel_if.sink       i_pixel,
    rcem_result_if.source    o_result
);

    t_cmd    cmd;
    t_status status;

    rcem_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pixel.valid),
        .o_in_ready (i_pixel.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rcem_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pixel    (i_pixel.pixel),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_result   (o_result)
    );

endmodule

`default_nettype wire

// ===== design/rcem_ctrl.sv =====
// controller state machine sequencing one pixel word through the datapath
`default_nettype none

module rcem_ctrl
    import rcem_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_SUM  = 5'b00100,
        S_ROOT = 5'b01000,
        S_LOAD = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.window = 1'b1;
                n_state      = i_status.emit ? S_SUM : S_IDLE;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.step = 1'b1;
                if (i_status.root_last) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/rcem_dpath.sv =====
// datapath: config, position counters, line store, window, squares and root unit
`default_nettype none
`include "roberts_cross_edge_magnitude_unit_defines.svh"

module rcem_dpath
    import rcem_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_idx,
    input  wire [CFG_W-1:0]      i_cfg_data,
    input  wire [PIX_W-1:0]      i_pixel,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    rcem_result_if.source        o_result
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [CFG_W-1:0]  r_width;
    logic [CFG_W-1:0]  r_height;
    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_row;
    logic [PIX_W-1:0]  r_line [MAX_WIDTH];
    logic [PIX_W-1:0]  r_upper;
    logic [PIX_W-1:0]  r_pix;
    logic [PIX_W-1:0]  r_left;
    logic [PIX_W-1:0]  r_ul;
    logic              r_emit;
    logic              r_eol;
    logic              r_eof;
    logic [SQ_W-1:0]   r_sqx;
    logic [SQ_W-1:0]   r_sqy;
    logic [RAD_W-1:0]  r_rem;
    logic [RAD_W-1:0]  r_bit;
    logic [ROOT_W-1:0] r_root;
    logic              r_out_valid;
    logic [MAG_W-1:0]  r_mag;
    logic              r_out_eol;
    logic              r_out_eof;

    logic [31:0]       col_nx;
    logic [31:0]       row_nx;
    logic [31:0]       wid_cfg;
    logic [31:0]       hgt_cfg;
    logic              last_col;
    logic              last_row;
    logic [PIX_W-1:0]  gx;
    logic [PIX_W-1:0]  gy;
    logic [ROOT_W-1:0] trial;
    logic              take;

    // effective size is the register saturated to 2..max
    always_comb begin
        col_nx   = 32'(r_col) + 32'd1;
        row_nx   = 32'(r_row) + 32'd1;
        wid_cfg  = 32'(r_width);
        hgt_cfg  = 32'(r_height);
        last_col = (wid_cfg < 32'd2) ? (col_nx >= 32'd2)
                 : ((col_nx >= wid_cfg) || (col_nx >= 32'(MAX_WIDTH)));
        last_row = (hgt_cfg < 32'd2) ? (row_nx >= 32'd2)
                 : ((row_nx >= hgt_cfg) || (row_nx >= 32'(MAX_HEIGHT)));
        gx       = (r_ul > r_pix) ? (r_ul - r_pix) : (r_pix - r_ul);
        gy       = (r_left > r_upper) ? (r_left - r_upper) : (r_upper - r_left);
        trial    = r_root + {1'b0, r_bit};
        take     = ({1'b0, r_rem} >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_IMAGE_WIDTH;
            r_height <= RST_IMAGE_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // line store, read before write at the current column
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_line[r_col] <= i_pixel;
            r_upper       <= r_line[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
            r_ul   <= '0;
            r_emit <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_emit <= (r_row != '0) && (r_col != '0);
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (i_cmd.window) begin
                r_ul   <= r_upper;
                r_left <= r_pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix <= i_pixel;
            r_eol <= last_col;
            r_eof <= last_col && last_row;
        end
        if (i_cmd.window) begin
            r_sqx <= {{PIX_W{1'b0}}, gx} * {{PIX_W{1'b0}}, gx};
            r_sqy <= {{PIX_W{1'b0}}, gy} * {{PIX_W{1'b0}}, gy};
        end
        if (i_cmd.sum) begin
            r_rem  <= {1'b0, r_sqx} + {1'b0, r_sqy};
            r_root <= '0;
            r_bit  <= ROOT_FIRST_BIT;
        end else if (i_cmd.step) begin
            if (take) begin
                r_rem  <= r_rem - trial[RAD_W-1:0];
                r_root <= (r_root >> 1) + {1'b0, r_bit};
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.load) begin
            r_mag     <= r_root[MAG_W-1:0];
            r_out_eol <= r_eol;
            r_out_eof <= r_eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.emit      = r_emit;
    assign o_status.root_last = r_bit[0];
    assign o_status.out_free  = !r_out_valid || o_result.ready;

    assign o_result.valid        = r_out_valid;
    assign o_result.magnitude    = r_mag;
    assign o_result.end_of_line  = r_out_eol;
    assign o_result.end_of_frame = r_out_eof;

    `RCEM_ASSERT_IMP(a_mag_range, r_out_valid, r_mag <= MAG_MAX, "magnitude above 360")
    `RCEM_ASSERT_IMP(a_step_live, i_cmd.step, r_bit != '0, "root step past last bit")
    `RCEM_ASSERT_IMP(a_load_free, i_cmd.load, !r_out_valid || o_result.ready,
                     "result overwritten")
    `RCEM_ASSERT_NXT(a_load_shows, i_cmd.load, r_out_valid, "loaded result not shown")

endmodule

`default_nettype wire
